// ===== hw/rtl/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Shared constants, codes and the command and status records that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

  // Default sizes of the list store.
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_WORD_WIDTH = 32;

  // Fixed widths of the channel fields.
  localparam int OP_W  = 2;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 5;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SORT   = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Index register updates.
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_LEN  = 3'd1,
    IDX_POS  = 3'd2,
    IDX_ZERO = 3'd3,
    IDX_INC  = 3'd4,
    IDX_DEC  = 3'd5
  } idx_cmd_e;

  // Read address selection relative to the index register.
  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_M1 = 2'd1,
    RD_IDX_P1 = 2'd2,
    RD_IDX_P2 = 2'd3
  } rd_sel_e;

  // Write data selection.
  typedef enum logic [1:0] {
    WR_RDATA = 2'd0,
    WR_VALUE = 2'd1,
    WR_SORT  = 2'd2,
    WR_CUR   = 2'd3
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     in_take;
    idx_cmd_e idx_cmd;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     len_inc;
    logic     len_dec;
    logic     end_ld;
    logic     end_dec;
    logic     swap_clr;
    logic     cur_ld;
    logic     sort_step;
    logic     res_load;
    logic     res_dump;
    status_e  res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic full;
    logic ins_bad;
    logic del_bad;
    logic len_lt2;
    logic len_zero;
    logic idx_ge_pos;
    logic idx_p1_lt_len;
    logic dump_last;
    logic sort_more;
    logic sort_again;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bole_if.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine channels
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface bole_in_if;
  import bole_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface bole_out_if;
  import bole_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [VAL_W-1:0]  entry_value;
  logic [CNT_W-1:0]         entry_count;
  logic                     last;

  modport source (output valid, output status, output entry_value,
                  output entry_count, output last, input ready);
  modport sink (input valid, input status, input entry_value, input entry_count,
                input last, output ready);
endinterface

// ===== hw/rtl/bole_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine controller
// One-hot state machine that sequences insert, delete, sort and dump over the
// datapath, with at most one memory read and one memory write per step.
// ----------------------------------------------------------------------------
module bole_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bole_pkg::dp_stat_t stat_i,
  output bole_pkg::dp_cmd_t  cmd_o
);
  import bole_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0_0000_0000_0001,
    S_CHECK     = 13'b0_0000_0000_0010,
    S_INS_RD    = 13'b0_0000_0000_0100,
    S_INS_WR    = 13'b0_0000_0000_1000,
    S_DEL_RD    = 13'b0_0000_0001_0000,
    S_DEL_WR    = 13'b0_0000_0010_0000,
    S_SRT_START = 13'b0_0000_0100_0000,
    S_SRT_LOAD  = 13'b0_0000_1000_0000,
    S_SRT_STEP  = 13'b0_0001_0000_0000,
    S_SRT_END   = 13'b0_0010_0000_0000,
    S_DUMP_RD   = 13'b0_0100_0000_0000,
    S_DUMP_EMIT = 13'b0_1000_0000_0000,
    S_RESULT    = 13'b1_0000_0000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              st_d    = ST_FULL;
              state_d = S_RESULT;
            end else if (stat_i.ins_bad) begin
              st_d    = ST_BADPOS;
              state_d = S_RESULT;
            end else begin
              cmd_o.idx_cmd = IDX_LEN;
              state_d       = S_INS_RD;
            end
          end
          OP_DELETE: begin
            if (stat_i.del_bad) begin
              st_d    = ST_BADPOS;
              state_d = S_RESULT;
            end else begin
              cmd_o.idx_cmd = IDX_POS;
              state_d       = S_DEL_RD;
            end
          end
          OP_SORT: begin
            if (stat_i.len_lt2) begin
              st_d    = ST_OK;
              state_d = S_RESULT;
            end else begin
              cmd_o.end_ld   = 1'b1;
              cmd_o.swap_clr = 1'b1;
              cmd_o.idx_cmd  = IDX_ZERO;
              state_d        = S_SRT_START;
            end
          end
          OP_DUMP: begin
            if (stat_i.len_zero) begin
              st_d    = ST_EMPTY;
              state_d = S_RESULT;
            end else begin
              cmd_o.idx_cmd = IDX_ZERO;
              state_d       = S_DUMP_RD;
            end
          end
          default: begin
            st_d    = ST_OK;
            state_d = S_RESULT;
          end
        endcase
      end
      // Insert: shift the tail up by one, then place the new value.
      S_INS_RD: begin
        if (stat_i.idx_ge_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_M1;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_VALUE;
          cmd_o.len_inc = 1'b1;
          st_d          = ST_OK;
          state_d       = S_RESULT;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_RDATA;
        cmd_o.idx_cmd = IDX_DEC;
        state_d       = S_INS_RD;
      end
      // Delete: shift the tail down by one over the removed entry.
      S_DEL_RD: begin
        if (stat_i.idx_p1_lt_len) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_P1;
          state_d      = S_DEL_WR;
        end else begin
          cmd_o.len_dec = 1'b1;
          st_d          = ST_OK;
          state_d       = S_RESULT;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_RDATA;
        cmd_o.idx_cmd = IDX_INC;
        state_d       = S_DEL_RD;
      end
      // Sort: one bubble pass carries the larger word forward in a register.
      S_SRT_START: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_SRT_LOAD;
      end
      S_SRT_LOAD: begin
        cmd_o.cur_ld = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX_P1;
        state_d      = S_SRT_STEP;
      end
      S_SRT_STEP: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_SORT;
        cmd_o.sort_step = 1'b1;
        cmd_o.idx_cmd   = IDX_INC;
        if (stat_i.sort_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_P2;
        end else begin
          state_d = S_SRT_END;
        end
      end
      S_SRT_END: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_CUR;
        cmd_o.end_dec = 1'b1;
        if (stat_i.sort_again) begin
          cmd_o.swap_clr = 1'b1;
          cmd_o.idx_cmd  = IDX_ZERO;
          state_d        = S_SRT_START;
        end else begin
          st_d    = ST_OK;
          state_d = S_RESULT;
        end
      end
      // Dump: read each entry and hand it to the output register.
      S_DUMP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_dump = 1'b1;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_cmd = IDX_INC;
            state_d       = S_DUMP_RD;
          end
        end
      end
      S_RESULT: begin
        cmd_o.res_status = st_q;
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

// ===== hw/rtl/bole_dp.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine datapath
// Entry memory with one registered read port and one write port, the list
// length, the walking index, the sort carry and the result register.
// ----------------------------------------------------------------------------
module bole_dp #(
  parameter int CAPACITY   = bole_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = bole_pkg::DEF_WORD_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bole_pkg::dp_cmd_t                cmd_i,
  output bole_pkg::dp_stat_t               stat_o,
  input  logic [bole_pkg::OP_W-1:0]        in_operation_i,
  input  logic [bole_pkg::POS_W-1:0]       in_position_i,
  input  logic signed [bole_pkg::VAL_W-1:0] in_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bole_pkg::ST_W-1:0]        out_status_o,
  output logic signed [bole_pkg::VAL_W-1:0] out_entry_value_o,
  output logic [bole_pkg::CNT_W-1:0]       out_entry_count_o,
  output logic                             out_last_o
);
  import bole_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  // Entry memory, no reset: only entries below the length are read.
  logic [WORD_WIDTH-1:0] mem_q [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic [IW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] wr_data;

  op_e                   op_q;
  logic [POS_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] val_q;
  logic [LW-1:0]         len_q, len_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [LW-1:0]         end_q, end_d;
  logic                  swapped_q, swapped_d;
  logic [WORD_WIDTH-1:0] cur_q, cur_d;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [VAL_W-1:0]      out_entry_q;
  logic [CNT_W-1:0]      out_count_q;
  logic                  out_last_q;

  logic [CW-1:0]         pos_w, len_w, idx_w, end_w, pos_m1;
  logic signed [63:0]    val_ext;
  logic [63:0]           rdata_ext;
  logic [15:0]           len_ext;
  logic                  cur_gt;
  logic                  out_free;

  // Compare operands at a common width.
  assign pos_w     = CW'(pos_q);
  assign len_w     = CW'(len_q);
  assign idx_w     = CW'(idx_q);
  assign end_w     = CW'(end_q);
  assign pos_m1    = pos_w - CW'(1);
  assign val_ext   = 64'(in_value_i);
  assign rdata_ext = 64'(rdata_q);
  assign len_ext   = 16'(len_q);
  assign cur_gt    = $signed(cur_q) > $signed(rdata_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // Status toward the controller.
  always_comb begin
    stat_o.op            = op_q;
    stat_o.full          = len_w >= CW'(CAPACITY);
    stat_o.ins_bad       = (pos_w == '0) || (pos_w > len_w + CW'(1));
    stat_o.del_bad       = (pos_w == '0) || (pos_w > len_w);
    stat_o.len_lt2       = len_w < CW'(2);
    stat_o.len_zero      = len_w == '0;
    stat_o.idx_ge_pos    = idx_w >= pos_w;
    stat_o.idx_p1_lt_len = (idx_w + CW'(1)) < len_w;
    stat_o.dump_last     = (idx_w + CW'(1)) == len_w;
    stat_o.sort_more     = (idx_w + CW'(2)) < end_w;
    stat_o.sort_again    = swapped_q && (end_w > CW'(2));
    stat_o.out_free      = out_free;
  end

  // Read address and write data selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:    rd_addr = idx_q;
      RD_IDX_M1: rd_addr = idx_q - IW'(1);
      RD_IDX_P1: rd_addr = idx_q + IW'(1);
      RD_IDX_P2: rd_addr = idx_q + IW'(2);
      default:   rd_addr = idx_q;
    endcase
    case (cmd_i.wr_sel)
      WR_RDATA: wr_data = rdata_q;
      WR_VALUE: wr_data = val_q;
      WR_SORT:  wr_data = cur_gt ? rdata_q : cur_q;
      WR_CUR:   wr_data = cur_q;
      default:  wr_data = rdata_q;
    endcase
  end

  // Index, length and sort pass bookkeeping.
  always_comb begin
    case (cmd_i.idx_cmd)
      IDX_HOLD: idx_d = idx_q;
      IDX_LEN:  idx_d = len_q[IW-1:0];
      IDX_POS:  idx_d = pos_m1[IW-1:0];
      IDX_ZERO: idx_d = '0;
      IDX_INC:  idx_d = idx_q + IW'(1);
      IDX_DEC:  idx_d = idx_q - IW'(1);
      default:  idx_d = idx_q;
    endcase

    len_d = len_q;
    if (cmd_i.len_inc) begin
      len_d = len_q + LW'(1);
    end else if (cmd_i.len_dec) begin
      len_d = len_q - LW'(1);
    end

    end_d = end_q;
    if (cmd_i.end_ld) begin
      end_d = len_q;
    end else if (cmd_i.end_dec) begin
      end_d = end_q - LW'(1);
    end

    swapped_d = swapped_q;
    cur_d     = cur_q;
    if (cmd_i.swap_clr) begin
      swapped_d = 1'b0;
    end
    if (cmd_i.cur_ld) begin
      cur_d = rdata_q;
    end else if (cmd_i.sort_step) begin
      if (cur_gt) begin
        swapped_d = 1'b1;
      end else begin
        cur_d = rdata_q;
      end
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[idx_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Captured request and sort carry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      op_q  <= op_e'(in_operation_i);
      pos_q <= in_position_i;
      val_q <= val_ext[WORD_WIDTH-1:0];
    end
    cur_q <= cur_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      idx_q     <= '0;
      end_q     <= '0;
      swapped_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      idx_q     <= idx_d;
      end_q     <= end_d;
      swapped_q <= swapped_d;
    end
  end

  // Result register: holds one result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_count_q <= len_ext[CNT_W-1:0];
      if (cmd_i.res_dump) begin
        out_status_q <= ST_OK;
        out_entry_q  <= rdata_ext[VAL_W-1:0];
        out_last_q   <= stat_o.dump_last;
      end else begin
        out_status_q <= cmd_i.res_status;
        out_entry_q  <= '0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_entry_value_o = out_entry_q;
  assign out_entry_count_o = out_count_q;
  assign out_last_o        = out_last_q;

  // The length moves by at most one entry per cycle.
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |->
      ((len_q == $past(len_q) + LW'(1)) || (len_q == $past(len_q) - LW'(1))))
    else $error("list length jumped by more than one");

  // An insert never grows the list past its capacity.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.len_inc |-> (len_w < CW'(CAPACITY)))
    else $error("insert into a full list");

  // Writes stay within the list or at its first free slot.
  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (idx_w <= len_w))
    else $error("memory write beyond the list");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> out_free)
    else $error("result register overwritten before its transfer");

endmodule

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of up to CAPACITY signed words with insert, delete, sort and
// dump operations, built as a controller and a memory-based datapath.
//
//   Channel  Dir  Handshake     Payload
//   in_ch_i  in   valid/ready   operation, position, value
//   out_ch_o out  valid/ready   status, entry_value, entry_count, last
//
// One item is in work at a time; each step makes at most one read and one write of the entry
// memory, whose single read port has a registered output. Insert shifts the entries from the
// position up by one, delete shifts the later entries down by one, sort makes bubble passes over
// the first n entries, n starting at the length and dropping by one per pass, and dump reads each entry.
// Reset leaves the list empty. A stalled result waits in the output register; the next item
// is taken meanwhile and only its results wait.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int CAPACITY   = bole_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = bole_pkg::DEF_WORD_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bole_in_if.sink   in_ch_i,
  bole_out_if.source out_ch_o
);
  import bole_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Operation sequencer.
  bole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Entry store and result register.
  bole_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_operation_i    (in_ch_i.operation),
    .in_position_i     (in_ch_i.position),
    .in_value_i        (in_ch_i.value),
    .out_valid_o       (out_ch_o.valid),
    .out_ready_i       (out_ch_o.ready),
    .out_status_o      (out_ch_o.status),
    .out_entry_value_o (out_ch_o.entry_value),
    .out_entry_count_o (out_ch_o.entry_count),
    .out_last_o        (out_ch_o.last)
  );

endmodule

// ===== tb/bounded_ordered_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine testbench
// Drives insert, delete, sort and dump requests through the request channel and checks every
// result against a shadow list kept in the testbench or, for typed table rows, against the
// row's own expectation. A short table of directed requests covers the empty list, the full
// list, bad positions and the extreme words. Random request traffic follows, alternating
// between growing and shrinking the list, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_test;
  import bole_pkg::*;

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int RAND_ITEMS  = 380;
  localparam int DRAIN_AT    = 200;
  localparam int SETTLE_CYC  = 320;

  // One result as the block should present it.
  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } list_result_t;

  // One row of the directed stimulus; typed rows carry their own expectation.
  typedef struct {
    op_e                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    int                      reps;
    logic                    rand_value;
    logic                    typed;
    status_e                 status;
    int                      count;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bole_in_if  in_ch ();
  bole_out_if out_ch ();

  bounded_ordered_list_engine i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // Clock with a period of 8 time units.
  always #4 clk_i = ~clk_i;

  // Shadow copy of the list and the results still owed by the block.
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_len;
  list_result_t            pending_results [$];

  int  err_cnt;
  int  checked_cnt;
  int  op_cnt [4];
  int  full_rejects;
  int  badpos_rejects;
  logic calm;

  // Directed requests: empty list, bad positions, extremes, fill and full.
  plan_row_t plan [0:17] = '{
    '{OP_DUMP,   8'd0,   32'sd0,          1,  1'b0, 1'b1, ST_EMPTY,  0},
    '{OP_DELETE, 8'd1,   32'sd0,          1,  1'b0, 1'b1, ST_BADPOS, 0},
    '{OP_SORT,   8'd0,   32'sd0,          1,  1'b0, 1'b1, ST_OK,     0},
    '{OP_INSERT, 8'd0,   32'sd5,          1,  1'b0, 1'b1, ST_BADPOS, 0},
    '{OP_INSERT, 8'd2,   32'sd5,          1,  1'b0, 1'b1, ST_BADPOS, 0},
    '{OP_INSERT, 8'd1,   32'h7FFF_FFFF,   1,  1'b0, 1'b1, ST_OK,     1},
    '{OP_SORT,   8'd0,   32'sd0,          1,  1'b0, 1'b1, ST_OK,     1},
    '{OP_INSERT, 8'd1,   32'h8000_0000,   1,  1'b0, 1'b1, ST_OK,     2},
    '{OP_INSERT, 8'd3,   -32'sd1,         1,  1'b0, 1'b1, ST_OK,     3},
    '{OP_DELETE, 8'd0,   32'sd0,          1,  1'b0, 1'b1, ST_BADPOS, 3},
    '{OP_DELETE, 8'd4,   32'sd0,          1,  1'b0, 1'b1, ST_BADPOS, 3},
    '{OP_INSERT, 8'd255, 32'sd7,          1,  1'b0, 1'b1, ST_BADPOS, 3},
    '{OP_INSERT, 8'd2,   32'sd0,          13, 1'b1, 1'b0, ST_OK,     0},
    '{OP_INSERT, 8'd1,   32'sd9,          1,  1'b0, 1'b1, ST_FULL,   16},
    '{OP_SORT,   8'd0,   32'sd0,          1,  1'b0, 1'b0, ST_OK,     0},
    '{OP_DUMP,   8'd0,   32'sd0,          1,  1'b0, 1'b0, ST_OK,     0},
    '{OP_DELETE, 8'd16,  32'sd0,          1,  1'b0, 1'b1, ST_OK,     15},
    '{OP_DELETE, 8'd255, 32'sd0,          1,  1'b0, 1'b1, ST_BADPOS, 15}
  };

  // Applies one request to the shadow list and returns the results it causes.
  task automatic list_apply(input op_e op, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val,
                            output list_result_t res [$]);
    list_result_t            r;
    logic signed [VAL_W-1:0] tmp;
    int                      p;
    int                      i;
    int                      top;
    logic                    swapped;
    res = {};
    p = int'(pos);
    r.status      = ST_OK;
    r.entry_value = '0;
    r.last        = 1'b1;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = shadow_len; i > p - 1; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = val;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_SORT: begin
        // Bubble passes with a shrinking end until a pass makes no swap.
        top = shadow_len;
        if (shadow_len >= 2) begin
          do begin
            swapped = 1'b0;
            for (i = 0; i + 1 < top; i++) begin
              if (shadow_list[i] > shadow_list[i+1]) begin
                tmp              = shadow_list[i];
                shadow_list[i]   = shadow_list[i+1];
                shadow_list[i+1] = tmp;
                swapped          = 1'b1;
              end
            end
            if (top > 0) top--;
          end while (swapped);
        end
      end
      default: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
      end
    endcase
    r.entry_count = CNT_W'(shadow_len);
    if (op == OP_DUMP && shadow_len > 0) begin
      for (i = 0; i < shadow_len; i++) begin
        r.entry_value = shadow_list[i];
        r.last        = (i + 1 == shadow_len);
        res.push_back(r);
      end
    end else begin
      res.push_back(r);
    end
  endtask

  // Idle time before a request: none during calm stretches, else mostly short.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random word: half full range, some near zero, some at the extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom;
    if (roll < 75) return $urandom_range(0, 8) - 4;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // Presents one request, waits for its transfer and records the expectation.
  task automatic send_request(input op_e op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val,
                              input logic typed, input status_e t_status,
                              input int t_count);
    int           gap;
    list_result_t res [$];
    list_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.position  <= pos;
    in_ch.value     <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    list_apply(op, pos, val, res);
    op_cnt[op]++;
    if (res[0].status == ST_FULL) full_rejects++;
    if (res[0].status == ST_BADPOS) badpos_rejects++;
    if (typed) begin
      r.status      = t_status;
      r.entry_value = '0;
      r.entry_count = CNT_W'(t_count);
      r.last        = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (res[k]) pending_results.push_back(res[k]);
    end
  endtask

  // Holds the request channel idle until every owed result has arrived.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result side: random back-pressure, mostly ready with short and long stalls.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        if ($urandom_range(0, 99) < 70) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(1, 20);
        end else begin
          out_ch.ready <= 1'b0;
          hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 30);
        end
      end else begin
        hold--;
      end
    end
  end

  // Checks every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d value %0d count %0d last %0d",
                 $time, out_ch.status, out_ch.entry_value, out_ch.entry_count,
                 out_ch.last);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_cnt++;
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_ch.status);
          err_cnt++;
        end
        if (out_ch.entry_value !== exp_r.entry_value) begin
          $display("%0t: entry_value expected %0d actual %0d", $time,
                   exp_r.entry_value, out_ch.entry_value);
          err_cnt++;
        end
        if (out_ch.entry_count !== exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   exp_r.entry_count, out_ch.entry_count);
          err_cnt++;
        end
        if (out_ch.last !== exp_r.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_r.last,
                   out_ch.last);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random traffic and the final check.
  initial begin
    op_e                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    logic                    grow;
    int                      roll;
    err_cnt         = 0;
    checked_cnt     = 0;
    full_rejects    = 0;
    badpos_rejects  = 0;
    op_cnt          = '{default: 0};
    shadow_len      = 0;
    calm            = 1'b0;
    grow            = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.position  = '0;
    in_ch.value     = '0;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      for (int n = 0; n < plan[r].reps; n++) begin
        val = plan[r].rand_value ? pick_value() : plan[r].value;
        send_request(plan[r].op, plan[r].pos, val, plan[r].typed, plan[r].status,
                     plan[r].count);
      end
    end
    wait_results_done();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Alternate growing and shrinking phases so the list swings end to end.
      if (n % 60 == 0) grow = ~grow;
      calm = (n % 50) < 8;
      if (n == DRAIN_AT) wait_results_done();
      roll = $urandom_range(0, 99);
      if (grow) begin
        op = (roll < 60) ? OP_INSERT : (roll < 78) ? OP_DELETE :
             (roll < 88) ? OP_SORT : OP_DUMP;
      end else begin
        op = (roll < 22) ? OP_INSERT : (roll < 75) ? OP_DELETE :
             (roll < 87) ? OP_SORT : OP_DUMP;
      end
      // Positions are mostly in range, with some anywhere in the field.
      if ($urandom_range(0, 99) < 12) begin
        pos = POS_W'($urandom_range(0, 255));
      end else if (op == OP_INSERT) begin
        pos = POS_W'($urandom_range(1, shadow_len + 1));
      end else if (op == OP_DELETE && shadow_len > 0) begin
        pos = POS_W'($urandom_range(1, shadow_len));
      end else begin
        pos = POS_W'($urandom_range(0, 255));
      end
      send_request(op, pos, pick_value(), 1'b0, ST_OK, 0);
    end

    wait_results_done();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      err_cnt++;
    end
    $display("Requests: %0d insert, %0d delete, %0d sort, %0d dump; %0d results checked.",
             op_cnt[OP_INSERT], op_cnt[OP_DELETE], op_cnt[OP_SORT], op_cnt[OP_DUMP],
             checked_cnt);
    $display("Rejections seen: %0d on a full list, %0d for a bad position.",
             full_rejects, badpos_rejects);
    if (err_cnt == 0) begin
      $display("[bounded_ordered_list_engine] OK");
    end else begin
      $display("[bounded_ordered_list_engine] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #12_000_000;
    $display("%0t: timeout", $time);
    $display("[bounded_ordered_list_engine] ERROR");
    $finish;
  end

endmodule
